FILE: hw/rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by the decode stage, the top level and the checker.
package utf8d_pkg;

  localparam logic [20:0] REPL_CHAR   = 21'h00FFFD;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  remaining_count;
    logic [14:0] partial_code;
    logic [2:0]  taken_count;
  } dec_state_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic [2:0]  bytes_consumed;
    logic        last;
  } result_t;

endpackage

FILE: hw/rtl/utf8d_decode.sv
// Combinational decode of one byte against the open-sequence state.
// Depends on utf8d_pkg for the state and result types.
module utf8d_decode
  import utf8d_pkg::*;
(
  input  dec_state_t  st,
  input  logic [7:0]  in_byte,
  output dec_state_t  st_next,
  output result_t     res0,
  output result_t     res1,
  output logic [1:0]  res_count
);

  logic        seq_open;
  logic        is_cont;
  logic [20:0] code;
  logic [1:0]  rem_dec;
  logic [2:0]  taken_inc;
  logic        lead_has_res;
  result_t     lead_res;
  dec_state_t  lead_st;

  assign seq_open  = (st.remaining_count != 2'd0);
  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign code      = {st.partial_code, in_byte[5:0]};
  assign rem_dec   = st.remaining_count - 2'd1;
  assign taken_inc = st.taken_count + 3'd1;

  // Treat the byte as the start of a new sequence.
  always_comb begin
    lead_has_res = 1'b0;
    lead_res     = '{code_point: REPL_CHAR, is_replacement: 1'b1,
                     bytes_consumed: 3'd1, last: 1'b1};
    lead_st      = '0;
    if (in_byte[7] == 1'b0) begin
      lead_has_res        = 1'b1;
      lead_res.code_point = {13'd0, in_byte};
      lead_res.is_replacement = 1'b0;
    end else if (in_byte inside {[8'hC0:8'hDF]}) begin
      lead_st = '{remaining_count: 2'd1, partial_code: {10'd0, in_byte[4:0]},
                  taken_count: 3'd1};
    end else if (in_byte inside {[8'hE0:8'hEF]}) begin
      lead_st = '{remaining_count: 2'd2, partial_code: {11'd0, in_byte[3:0]},
                  taken_count: 3'd1};
    end else if (in_byte inside {[8'hF0:8'hF7]}) begin
      lead_st = '{remaining_count: 2'd3, partial_code: {12'd0, in_byte[2:0]},
                  taken_count: 3'd1};
    end else begin
      // stray continuation or invalid lead
      lead_has_res = 1'b1;
    end
  end

  always_comb begin
    st_next   = lead_st;
    res0      = lead_res;
    res1      = lead_res;
    res_count = {1'b0, lead_has_res};
    if (seq_open && is_cont) begin
      res1 = lead_res;
      if (rem_dec == 2'd0) begin
        st_next   = '0;
        res0      = '{code_point: code, is_replacement: 1'b0,
                      bytes_consumed: taken_inc, last: 1'b1};
        res_count = 2'd1;
      end else begin
        st_next   = '{remaining_count: rem_dec, partial_code: code[14:0],
                      taken_count: taken_inc};
        res_count = 2'd0;
      end
    end else if (seq_open) begin
      // broken sequence: replacement first, then the byte as a new lead
      res0      = '{code_point: REPL_CHAR, is_replacement: 1'b1,
                    bytes_consumed: st.taken_count, last: !lead_has_res};
      res1      = lead_res;
      res_count = lead_has_res ? 2'd2 : 2'd1;
    end
  end

endmodule

FILE: hw/rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, state, result queue.
// Depends on utf8d_pkg and utf8d_decode.
//
// Takes one byte per cycle while in_stall is low and returns decoded code
// points, one result per cycle while out_stall is low. A byte is held in an
// input register, decoded there combinationally against the open sequence,
// and its results (none, one, or two for a broken sequence followed by an
// ASCII or invalid byte) go into a four-entry result queue that drives the
// output ports. They are written when the byte leaves the input register
// and reach the output behind any results already queued. Bytes flow at one
// per cycle as long as the queue has two free slots; since the output takes
// at most one result per cycle, bytes that yield two results fill the queue,
// and the input stalls once it backs up. Overlong forms and surrogates are
// passed through, and 4-byte leads can give values up to 0x1FFFFF.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        is_replacement,
  output logic [2:0]  bytes_consumed,
  output logic        last
);

  logic              ibuf_valid;
  logic [7:0]        ibuf_byte;
  dec_state_t        st;
  dec_state_t        st_next;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_count;
  logic              consume;
  logic              pop;
  logic [1:0]        push_n;
  result_t           queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  result_t           head;

  utf8d_decode u_decode (
    .st        (st),
    .in_byte   (ibuf_byte),
    .st_next   (st_next),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  // Advance the input register only when the queue can take two results.
  assign consume  = ibuf_valid && (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_stall = ibuf_valid && !consume;
  assign push_n   = consume ? res_count : 2'd0;
  assign pop      = out_valid && !out_stall;
  assign count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (!in_stall) begin
      ibuf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ibuf_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (consume) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  assign head           = queue[rd_ptr];
  assign out_valid      = (count != '0);
  assign code_point     = head.code_point;
  assign is_replacement = head.is_replacement;
  assign bytes_consumed = head.bytes_consumed;
  assign last           = head.last;

endmodule

FILE: hw/rtl/utf8d_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8d_pkg for the replacement code point.
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] code_point,
  input logic        is_replacement,
  input logic [2:0]  bytes_consumed,
  input logic        last
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(last))
    else $error("stalled result transaction changed");

  a_repl_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_replacement |-> code_point == REPL_CHAR)
    else $error("replacement result without U+FFFD");

  // only a broken sequence ahead of another result may be non-final
  a_good_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_replacement |-> last)
    else $error("decoded code point not marked last");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bytes_consumed >= 3'd1 && bytes_consumed <= 3'd4)
    else $error("byte count out of range");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for utf8_stream_decoder: directed byte table, then random streams.
// Depends on utf8d_pkg for result_t and REPL_CHAR; holds its own decoder model for prediction.
module tb;
  import utf8d_pkg::*;

  localparam int RANDOM_BYTES = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    want;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] code_point;
  logic        is_replacement;
  logic [2:0]  bytes_consumed;
  logic        last;

  byte_row_t byte_plan[$];
  result_t   pending_points[$];
  int        bytes_taken = 0;
  int        fail_count  = 0;
  int        cycle_count = 0;
  bit        send_done   = 1'b0;

  // decoder model state
  logic [1:0]  seq_left  = '0;
  logic [14:0] seq_bits  = '0;
  logic [2:0]  seq_taken = '0;

  utf8_stream_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .bytes_consumed (bytes_consumed),
    .last           (last)
  );

  always #6 clk = ~clk;

  function automatic result_t make_point(logic [20:0] cp, logic repl, logic [2:0] n,
                                         logic fin);
    result_t r;
    r.code_point     = cp;
    r.is_replacement = repl;
    r.bytes_consumed = n;
    r.last           = fin;
    return r;
  endfunction

  // Returns the number of results this byte causes and updates the model state.
  function automatic int decode_byte(input logic [7:0] b, output result_t r0,
                                     output result_t r1);
    logic [20:0] code;
    result_t     lead_res;
    bit          lead_emits;
    int          n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (seq_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code      = {seq_bits, b[5:0]};
        seq_taken = seq_taken + 3'd1;
        seq_left  = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          r0        = make_point(code, 1'b0, seq_taken, 1'b1);
          seq_bits  = '0;
          seq_taken = '0;
          return 1;
        end
        seq_bits = code[14:0];
        return 0;
      end
      // broken sequence: replace what was taken, then treat the byte as a lead
      r0        = make_point(REPL_CHAR, 1'b1, seq_taken, 1'b0);
      n         = 1;
      seq_left  = '0;
      seq_bits  = '0;
      seq_taken = '0;
    end
    lead_emits = 1'b0;
    lead_res   = '0;
    if (!b[7]) begin
      lead_res   = make_point({13'd0, b}, 1'b0, 3'd1, 1'b1);
      lead_emits = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      seq_bits = {10'd0, b[4:0]};
      seq_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_bits = {11'd0, b[3:0]};
      seq_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      seq_bits = {12'd0, b[2:0]};
      seq_left = 2'd3;
    end else begin
      lead_res   = make_point(REPL_CHAR, 1'b1, 3'd1, 1'b1);
      lead_emits = 1'b1;
    end
    if (!lead_emits) begin
      seq_taken = 3'd1;
      if (n == 1) r0.last = 1'b1;
      return n;
    end
    if (n == 0) r0 = lead_res;
    else r1 = lead_res;
    return n + 1;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    byte_row_t row;
    row.b     = b;
    row.typed = 1'b0;
    row.want  = '0;
    byte_plan.push_back(row);
  endfunction

  function automatic void add_typed(logic [7:0] b, logic [20:0] cp, logic repl,
                                    logic [2:0] n, logic fin);
    byte_row_t row;
    row.b     = b;
    row.typed = 1'b1;
    row.want  = make_point(cp, repl, n, fin);
    byte_plan.push_back(row);
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_lead(int len);
    case (len)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  function automatic void build_plan();
    int start;
    int len;
    int kind;
    // ASCII and replacement extremes
    add_typed(8'h00, 21'h0, 1'b0, 3'd1, 1'b1);
    add_typed(8'h7F, 21'h7F, 1'b0, 3'd1, 1'b1);
    add_typed(8'h80, REPL_CHAR, 1'b1, 3'd1, 1'b1);
    add_typed(8'hF8, REPL_CHAR, 1'b1, 3'd1, 1'b1);
    add_typed(8'hFF, REPL_CHAR, 1'b1, 3'd1, 1'b1);
    // overlong NUL passes through
    add_byte(8'hC0); add_byte(8'h80);
    add_byte(8'hDF); add_typed(8'hBF, 21'h7FF, 1'b0, 3'd2, 1'b1);
    add_byte(8'hEF); add_byte(8'hBF); add_typed(8'hBF, 21'hFFFF, 1'b0, 3'd3, 1'b1);
    add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF);
    add_typed(8'hBF, 21'h1FFFFF, 1'b0, 3'd4, 1'b1);
    // broken sequence followed by ASCII: two results
    add_byte(8'hE0); add_byte(8'h41);
    // broken sequence followed by a new lead: a single replacement marked last
    add_byte(8'hF0); add_byte(8'h90); add_typed(8'hC3, REPL_CHAR, 1'b1, 3'd2, 1'b1);
    add_typed(8'hA9, 21'hE9, 1'b0, 3'd2, 1'b1);
    // broken sequence followed by an invalid lead
    add_byte(8'hE1); add_byte(8'h80); add_byte(8'hFF);

    start = byte_plan.size();
    while (byte_plan.size() - start < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        add_byte(8'($urandom_range(0, 127)));
      end else if (kind <= 6) begin
        len = $urandom_range(2, 4);
        add_byte(rand_lead(len));
        repeat (len - 1) add_byte(rand_cont());
      end else if (kind == 7) begin
        add_byte($urandom_range(0, 1) ? rand_cont() : 8'($urandom_range(8'hF8, 8'hFF)));
      end else if (kind == 8) begin
        // truncated sequence: a following non-continuation byte breaks it
        len = $urandom_range(2, 4);
        add_byte(rand_lead(len));
        repeat ($urandom_range(0, len - 2)) add_byte(rand_cont());
      end else begin
        add_byte(8'($urandom));
      end
    end
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Sender: bursts of random length with random gaps.
  initial begin : drive_bytes
    int burst;
    int gap;
    build_plan();
    do @(negedge clk); while (rst);
    burst = 0;
    for (int i = 0; i < byte_plan.size(); i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_byte  <= byte_plan[i].b;
      do @(posedge clk); while (in_stall);
      burst--;
    end
    @(negedge clk);
    in_valid  <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: stall pattern per epoch, plus one long hold-off to back up the queue.
  initial begin : drive_stall
    logic [15:0] pattern;
    bit          held;
    held = 1'b0;
    forever begin
      pattern = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
      for (int k = 0; k < 64; k++) begin
        @(negedge clk);
        if (!held && bytes_taken >= 300) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          out_stall <= pattern[k % 16];
        end
      end
    end
  end

  // Predict on each accepted byte, check on each accepted result.
  always @(posedge clk) begin
    result_t r0;
    result_t r1;
    result_t got;
    result_t want;
    int      n;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        n = decode_byte(in_byte, r0, r1);
        if (byte_plan[bytes_taken].typed) begin
          pending_points.push_back(byte_plan[bytes_taken].want);
        end else begin
          if (n > 0) pending_points.push_back(r0);
          if (n > 1) pending_points.push_back(r1);
        end
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        got = make_point(code_point, is_replacement, bytes_consumed, last);
        if (pending_points.size() == 0) begin
          $error("unexpected result: code_point %0h", got.code_point);
          fail_count++;
        end else begin
          want = pending_points.pop_front();
          if (got.code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
            fail_count++;
          end
          if (got.is_replacement !== want.is_replacement) begin
            $error("is_replacement: expected %0d, got %0d", want.is_replacement,
                   got.is_replacement);
            fail_count++;
          end
          if (got.bytes_consumed !== want.bytes_consumed) begin
            $error("bytes_consumed: expected %0d, got %0d", want.bytes_consumed,
                   got.bytes_consumed);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : finish_run
    do @(posedge clk); while (!send_done);
    while (pending_points.size() != 0) @(posedge clk);
    // keep waiting so any extra result shows up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
